FILE: src/pwmm_pkg.sv
// ----------------------------------------------------------------------------
// pwmm_pkg: shared types and constants of the pwm duty and frequency meter
// Holds counter widths, divider sizing, payload structs and state encoding.
// ----------------------------------------------------------------------------
package pwmm_pkg;

  localparam int CountWidth = 16;
  localparam int PerWidth   = CountWidth + 1;
  localparam int TpsWidth   = 24;
  localparam int DutyWidth  = 7;
  localparam int DivWidth   = (TpsWidth > CountWidth + DutyWidth) ? TpsWidth
                                                                  : CountWidth + DutyWidth;
  localparam int StepWidth  = $clog2(DivWidth + 1);
  localparam int PctScale   = 100;
  localparam int TpsReset   = 100000;

  typedef enum logic [0:0] {
    OP_TICK    = 1'b0,
    OP_MEASURE = 1'b1
  } op_e;

  typedef struct packed {
    op_e  op;
    logic level;
  } in_t;

  typedef struct packed {
    logic [DutyWidth-1:0] duty_percent;
    logic [TpsWidth-1:0]  frequency;
    logic                 divide_error;
  } out_t;

  typedef struct packed {
    logic [CountWidth-1:0] high;
    logic [CountWidth-1:0] low;
  } lat_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

endpackage

FILE: src/pwm_input_duty_frequency_meter_top.sv
// ----------------------------------------------------------------------------
// pwm_input_duty_frequency_meter_top: pwm duty cycle and frequency meter
// Tick beats are taken one per cycle; a measure beat runs two serial dividers.
// A measure beat loads both bit-serial dividers, which then step in ST_DIV;
//   the result is held in ST_OUT; a zero period goes straight to ST_OUT.
// Throughput: ticks 1 per cycle always; a measure is taken only in ST_IDLE,
//   so measure beats stall while a result is in flight or waiting.
// Reset: counters and latches clear to zero, ticks_per_second to 100000.
// ----------------------------------------------------------------------------
module pwm_input_duty_frequency_meter_top
  import pwmm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TpsWidth-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o
);

  state_e               state_q, state_d;
  logic [StepWidth-1:0] cnt_q, cnt_d;
  logic                 err_q, err_d;
  logic [TpsWidth-1:0]  tps_q;
  lat_t                 lat;
  logic [PerWidth-1:0]  period;
  logic                 tick;
  logic                 measure;
  logic                 div_en;
  logic [DivWidth-1:0]  duty_num;
  logic [DivWidth-1:0]  duty_quo;
  logic [DivWidth-1:0]  freq_quo;

  // only measure beats wait on the dividers
  assign in_stall_o = (in_data_i.op == OP_MEASURE) && (state_q != ST_IDLE);
  assign tick       = in_valid_i && !in_stall_o && (in_data_i.op == OP_TICK);
  assign measure    = in_valid_i && !in_stall_o && (in_data_i.op == OP_MEASURE);

  pwmm_counter u_counter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick),
    .level_i (in_data_i.level),
    .lat_o   (lat)
  );

  assign period   = {1'b0, lat.high} + {1'b0, lat.low};
  assign duty_num = DivWidth'(lat.high) * DivWidth'(PctScale);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    div_en  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (measure) begin
          err_d   = (period == '0);
          cnt_d   = StepWidth'(DivWidth);
          state_d = (period == '0) ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        div_en = 1'b1;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == StepWidth'(1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      err_q   <= 1'b0;
      tps_q   <= TpsWidth'(TpsReset);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      if (cfg_we_i) begin
        tps_q <= cfg_data_i;
      end
    end
  end

  pwmm_div u_duty_div (
    .clk_i      (clk_i),
    .load_i     (measure),
    .en_i       (div_en),
    .dividend_i (duty_num),
    .divisor_i  (period),
    .quotient_o (duty_quo)
  );

  pwmm_div u_freq_div (
    .clk_i      (clk_i),
    .load_i     (measure),
    .en_i       (div_en),
    .dividend_i (DivWidth'(tps_q)),
    .divisor_i  (period),
    .quotient_o (freq_quo)
  );

  assign out_valid_o             = (state_q == ST_OUT);
  assign out_data_o.duty_percent = err_q ? '0 : duty_quo[DutyWidth-1:0];
  assign out_data_o.frequency    = err_q ? '0 : freq_quo[TpsWidth-1:0];
  assign out_data_o.divide_error = err_q;

endmodule

FILE: src/pwmm_counter.sv
// ----------------------------------------------------------------------------
// pwmm_counter: high and low time counters with edge capture
// Counts saturating high and low ticks and latches each phase on the edge.
// ----------------------------------------------------------------------------
module pwmm_counter
  import pwmm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic tick_i,
  input  logic level_i,
  output lat_t lat_o
);

  logic                  seen_low_q, seen_low_d;
  logic [CountWidth-1:0] high_run_q, high_run_d;
  logic [CountWidth-1:0] low_run_q, low_run_d;
  logic [CountWidth-1:0] high_lat_q, high_lat_d;
  logic [CountWidth-1:0] low_lat_q, low_lat_d;

  always_comb begin
    seen_low_d = seen_low_q;
    high_run_d = high_run_q;
    low_run_d  = low_run_q;
    high_lat_d = high_lat_q;
    low_lat_d  = low_lat_q;
    if (tick_i) begin
      if (level_i) begin
        // counters hold at all ones
        if (high_run_q != '1) begin
          high_run_d = high_run_q + 1'b1;
        end
        if (seen_low_q) begin
          low_lat_d  = low_run_q;
          low_run_d  = '0;
          seen_low_d = 1'b0;
        end
      end else begin
        if (low_run_q != '1) begin
          low_run_d = low_run_q + 1'b1;
        end
        if (!seen_low_q) begin
          high_lat_d = high_run_q;
          high_run_d = '0;
          seen_low_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_low_q <= 1'b0;
      high_run_q <= '0;
      low_run_q  <= '0;
      high_lat_q <= '0;
      low_lat_q  <= '0;
    end else begin
      seen_low_q <= seen_low_d;
      high_run_q <= high_run_d;
      low_run_q  <= low_run_d;
      high_lat_q <= high_lat_d;
      low_lat_q  <= low_lat_d;
    end
  end

  assign lat_o.high = high_lat_q;
  assign lat_o.low  = low_lat_q;

endmodule

FILE: src/pwmm_div.sv
// ----------------------------------------------------------------------------
// pwmm_div: bit-serial restoring divider
// Produces one quotient bit per enabled cycle, dividend shifted out msb first.
// ----------------------------------------------------------------------------
module pwmm_div
  import pwmm_pkg::*;
(
  input  logic                clk_i,
  input  logic                load_i,
  input  logic                en_i,
  input  logic [DivWidth-1:0] dividend_i,
  input  logic [PerWidth-1:0] divisor_i,
  output logic [DivWidth-1:0] quotient_o
);

  logic [DivWidth-1:0] quo_q, quo_d;
  logic [PerWidth-1:0] rem_q, rem_d;
  logic [PerWidth-1:0] dvs_q;
  logic [PerWidth:0]   trial;
  logic [PerWidth:0]   diff;
  logic                fits;

  always_comb begin
    trial = {rem_q, quo_q[DivWidth-1]};
    fits  = (trial >= {1'b0, dvs_q});
    diff  = trial - {1'b0, dvs_q};
    rem_d = fits ? diff[PerWidth-1:0] : trial[PerWidth-1:0];
    quo_d = {quo_q[DivWidth-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (en_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;

endmodule

FILE: dv/pwm_input_duty_frequency_meter_top_tb.sv
// ----------------------------------------------------------------------------
// pwm_input_duty_frequency_meter_top_tb: self-checking bench of the pwm meter
// Feeds tick and measure beats under random sender gaps and receiver stalls,
// predicts each measure result from a local model of the counters and
// latches, and compares every result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module pwm_input_duty_frequency_meter_top_tb;
  import pwmm_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 6;
  localparam int SettleCycles  = DivWidth + 8;
  localparam int DrainLimit    = 5000;
  localparam int LongHold      = 400;
  localparam int TimeoutCycles = 2000000;
  localparam logic [TpsWidth-1:0] TpsMax = {TpsWidth{1'b1}};
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [TpsWidth-1:0] cfg_data   = '0;
  logic                in_valid   = 1'b0;
  in_t                 in_data    = '0;
  logic                out_stall  = 1'b0;
  logic                in_stall;
  logic                out_valid;
  out_t                out_data;

  pwm_input_duty_frequency_meter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // local copy of the meter state
  logic [TpsWidth-1:0]   tps_q;
  logic                  seen_low_q;
  logic [CountWidth-1:0] high_run_q;
  logic [CountWidth-1:0] low_run_q;
  logic [CountWidth-1:0] high_lat_q;
  logic [CountWidth-1:0] low_lat_q;

  out_t expected_meas[$];
  int   failures    = 0;
  int   burst_left  = 0;
  bit   steady_send = 1'b0;
  int   hold_asks   = 0;

  task automatic clear_meter_state();
    tps_q      = TpsWidth'(TpsReset);
    seen_low_q = 1'b0;
    high_run_q = '0;
    low_run_q  = '0;
    high_lat_q = '0;
    low_lat_q  = '0;
  endtask

  task automatic count_tick(input logic lv);
    if (lv) begin
      if (high_run_q != CountMax) high_run_q++;
      if (seen_low_q) begin
        low_lat_q  = low_run_q;
        low_run_q  = '0;
        seen_low_q = 1'b0;
      end
    end else begin
      if (low_run_q != CountMax) low_run_q++;
      if (!seen_low_q) begin
        high_lat_q = high_run_q;
        high_run_q = '0;
        seen_low_q = 1'b1;
      end
    end
  endtask

  function automatic out_t pwm_measure();
    out_t              res;
    logic [63:0]       period;
    logic [63:0]       scaled;
    period = 64'(high_lat_q) + 64'(low_lat_q);
    res    = '0;
    if (period == 0) begin
      res.divide_error = 1'b1;
    end else begin
      scaled           = 64'(high_lat_q) * PctScale;
      res.duty_percent = DutyWidth'(scaled / period);
      res.frequency    = TpsWidth'(64'(tps_q) / period);
    end
    return res;
  endfunction

  // entered in the time step of a rising edge; returns at the accepting edge
  task automatic send_beat(input in_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    @(posedge clk_i);
    if (beat.op == OP_TICK) count_tick(beat.level);
    else expected_meas.push_back(pwm_measure());
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic offer(input in_t beat);
    if (burst_left == 0) begin
      if (!steady_send) idle_gap($urandom_range(0, 6));
      burst_left = $urandom_range(1, 16);
    end
    send_beat(beat);
    burst_left--;
  endtask

  task automatic offer_tick(input logic lv);
    in_t beat;
    beat.op    = OP_TICK;
    beat.level = lv;
    offer(beat);
  endtask

  task automatic offer_measure(input logic lv);
    in_t beat;
    beat.op    = OP_MEASURE;
    beat.level = lv;
    offer(beat);
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_meas.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_meas.size() != 0) begin
      $error("%0d expected measure results never arrived", expected_meas.size());
      failures++;
      expected_meas.delete();
    end
    // ticks give no result, so let any divide in flight finish too
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_tps(input logic [TpsWidth-1:0] value);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    tps_q     = value;
  endtask

  // pwm-shaped runs of one level with measures mixed in, plus some noise
  task automatic run_pwm_traffic(input int n_items);
    int   sent;
    int   run_len;
    int   pick;
    logic lv;
    sent = 0;
    lv   = $urandom_range(0, 1);
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        offer_measure($urandom_range(0, 1));
        sent++;
      end else if (pick < 18) begin
        offer_tick($urandom_range(0, 1));
        sent++;
      end else begin
        lv      = ~lv;
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                              : $urandom_range(1, 12);
        for (int i = 0; i < run_len && sent < n_items; i++) begin
          offer_tick(lv);
          sent++;
          if ($urandom_range(0, 19) == 0 && sent < n_items) begin
            offer_measure($urandom_range(0, 1));
            sent++;
          end
        end
      end
    end
  endtask

  task automatic test_reset_and_edges();
    steady_send = 1'b0;
    offer_measure(1'b1);              // nothing latched yet
    offer_tick(1'b0);                 // first low tick latches a zero high count
    offer_measure(1'b0);
    offer_tick(1'b1);                 // low count of one latched
    offer_measure(1'b1);
    offer_tick(1'b1);
    offer_tick(1'b1);
    offer_tick(1'b0);
    offer_measure(1'b0);
    offer_tick(1'b0);
    offer_tick(1'b1);
    offer_measure(1'b1);
    offer_tick(1'b0);
    offer_measure(1'b0);
  endtask

  task automatic test_tps_extremes();
    write_tps('0);
    offer_measure(1'b0);
    offer_tick(1'b1);
    offer_measure(1'b1);
    write_tps(TpsWidth'(1));
    offer_measure(1'b0);
    write_tps(TpsMax);
    offer_tick(1'b0);
    offer_tick(1'b1);
    offer_measure(1'b1);
    offer_tick(1'b0);
    offer_measure(1'b0);
  endtask

  task automatic test_long_runs();
    in_t beat;
    write_tps(TpsWidth'(TpsReset));
    beat.op    = OP_TICK;
    beat.level = 1'b1;
    repeat (100) send_beat(beat);
    beat.level = 1'b0;
    repeat (100) send_beat(beat);
    beat.level = 1'b1;
    send_beat(beat);
    beat.op = OP_MEASURE;
    send_beat(beat);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    write_tps(TpsMax);
    run_pwm_traffic(350);
    write_tps(TpsWidth'(1));
    steady_send = 1'b1;
    run_pwm_traffic(350);
    steady_send = 1'b0;
    write_tps(TpsWidth'($urandom_range(1, TpsMax)));
    run_pwm_traffic(350);
    write_tps(TpsWidth'(TpsReset));
    run_pwm_traffic(350);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    hold_asks++;
    steady_send = 1'b1;
    run_pwm_traffic(150);
    steady_send = 1'b0;
  endtask

  task automatic test_sender_pause();
    run_pwm_traffic(50);
    wait_idle();
    run_pwm_traffic(50);
  endtask

  // receiver stall pattern, with a long hold on request
  int stall_mode = 0;
  int mode_left  = 0;
  int hold_taken = 0;
  int hold_left  = 0;
  int stall_tick = 0;

  always @(posedge clk_i) begin
    stall_tick++;
    if (hold_taken != hold_asks) begin
      hold_taken = hold_asks;
      hold_left  = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 150);
      end
      mode_left--;
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall <= ($urandom_range(0, 9) < 7);
        end
        default: begin
          out_stall <= ((stall_tick % 5) < 2);
        end
      endcase
    end
  end

  // outputs are stable at the falling edge; a beat seen here moves at the next rise
  always @(negedge clk_i) begin : check_result
    out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_meas.size() == 0) begin
        $error("unexpected measure result %p", out_data);
        failures++;
      end else begin
        want = expected_meas.pop_front();
        if (out_data.duty_percent !== want.duty_percent) begin
          $error("duty_percent: expected %0d, actual %0d",
                 want.duty_percent, out_data.duty_percent);
          failures++;
        end
        if (out_data.frequency !== want.frequency) begin
          $error("frequency: expected %0d, actual %0d", want.frequency, out_data.frequency);
          failures++;
        end
        if (out_data.divide_error !== want.divide_error) begin
          $error("divide_error: expected %0b, actual %0b",
                 want.divide_error, out_data.divide_error);
          failures++;
        end
      end
    end
  end

  initial begin
    clear_meter_state();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_and_edges();
    test_tps_extremes();
    test_long_runs();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();
    wait_idle();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
src/pwmm_pkg.sv
src/pwmm_counter.sv
src/pwmm_div.sv
src/pwm_input_duty_frequency_meter_top.sv
dv/pwm_input_duty_frequency_meter_top_tb.sv
